// ===== hw/rtl/rvenc_pkg.sv =====
// Package for the RV32IM instruction encoder: mnemonic codes, format codes,
// base opcode constants and the code lookup function.
// No dependencies; used by rv32im_instruction_encoder.
package rvenc_pkg;

    // Mnemonic codes accepted on the opcode input.
    typedef enum logic [5:0] {
        MN_LUI, MN_AUIPC, MN_JAL, MN_JALR,
        MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU,
        MN_LB, MN_LH, MN_LW, MN_LBU, MN_LHU,
        MN_SB, MN_SH, MN_SW,
        MN_ADDI, MN_SLTI, MN_SLTIU, MN_XORI, MN_ORI, MN_ANDI,
        MN_SLLI, MN_SRLI, MN_SRAI,
        MN_ADD, MN_SUB, MN_SLL, MN_SLT, MN_SLTU, MN_XOR, MN_SRL, MN_SRA,
        MN_OR, MN_AND, MN_MUL, MN_MULH, MN_MULHSU, MN_MULHU, MN_DIV,
        MN_DIVU, MN_REM, MN_REMU,
        MN_FENCE, MN_FENCE_TSO, MN_ECALL, MN_EBREAK, MN_PAUSE
    } t_mnemonic;

    // Instruction formats, which decide where the operands are placed.
    typedef enum logic [3:0] {
        FMT_U, FMT_J, FMT_I, FMT_B, FMT_S, FMT_IA, FMT_SRAI, FMT_R,
        FMT_FENCE, FMT_FIXED
    } t_fmt;

    // One decoded mnemonic: known flag, format and base word.
    typedef struct packed {
        logic        known;
        t_fmt        fmt;
        logic [31:0] base;
    } t_code_entry;

    // Major opcodes.
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;

    // funct7 values of the register-register group.
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    // Upper bits of the SRAI immediate (immediate bit 10 set).
    localparam logic [6:0] SRAI_IMM_HI = 7'b0100000;

    // Fixed instruction words.
    localparam logic [31:0] WORD_FENCE_TSO = 32'h8330000F;
    localparam logic [31:0] WORD_ECALL     = 32'h00000073;
    localparam logic [31:0] WORD_EBREAK    = 32'h00100073;
    localparam logic [31:0] WORD_PAUSE     = 32'h0100000F;

    // Builds a base word from opcode, funct3 and funct7.
    function automatic logic [31:0] enc(input logic [6:0] op, input logic [2:0] f3,
                                        input logic [6:0] f7);
        enc = {f7, 10'd0, f3, 5'd0, op};
    endfunction

    function automatic t_code_entry make(input t_fmt fmt, input logic [31:0] base);
        make = '{known: 1'b1, fmt: fmt, base: base};
    endfunction

    // Maps a mnemonic code to its format and base word.
    function automatic t_code_entry lookup(input logic [5:0] code);
        t_code_entry e;
        e = '{known: 1'b0, fmt: FMT_FIXED, base: 32'd0};
        case (code)
            MN_LUI:       e = make(FMT_U, enc(OPC_LUI, 3'd0, F7_BASE));
            MN_AUIPC:     e = make(FMT_U, enc(OPC_AUIPC, 3'd0, F7_BASE));
            MN_JAL:       e = make(FMT_J, enc(OPC_JAL, 3'd0, F7_BASE));
            MN_JALR:      e = make(FMT_I, enc(OPC_JALR, 3'd0, F7_BASE));
            MN_BEQ:       e = make(FMT_B, enc(OPC_BRANCH, 3'd0, F7_BASE));
            MN_BNE:       e = make(FMT_B, enc(OPC_BRANCH, 3'd1, F7_BASE));
            MN_BLT:       e = make(FMT_B, enc(OPC_BRANCH, 3'd4, F7_BASE));
            MN_BGE:       e = make(FMT_B, enc(OPC_BRANCH, 3'd5, F7_BASE));
            MN_BLTU:      e = make(FMT_B, enc(OPC_BRANCH, 3'd6, F7_BASE));
            MN_BGEU:      e = make(FMT_B, enc(OPC_BRANCH, 3'd7, F7_BASE));
            MN_LB:        e = make(FMT_I, enc(OPC_LOAD, 3'd0, F7_BASE));
            MN_LH:        e = make(FMT_I, enc(OPC_LOAD, 3'd1, F7_BASE));
            MN_LW:        e = make(FMT_I, enc(OPC_LOAD, 3'd2, F7_BASE));
            MN_LBU:       e = make(FMT_I, enc(OPC_LOAD, 3'd4, F7_BASE));
            MN_LHU:       e = make(FMT_I, enc(OPC_LOAD, 3'd5, F7_BASE));
            MN_SB:        e = make(FMT_S, enc(OPC_STORE, 3'd0, F7_BASE));
            MN_SH:        e = make(FMT_S, enc(OPC_STORE, 3'd1, F7_BASE));
            MN_SW:        e = make(FMT_S, enc(OPC_STORE, 3'd2, F7_BASE));
            MN_ADDI:      e = make(FMT_IA, enc(OPC_OPIMM, 3'd0, F7_BASE));
            MN_SLTI:      e = make(FMT_IA, enc(OPC_OPIMM, 3'd2, F7_BASE));
            MN_SLTIU:     e = make(FMT_IA, enc(OPC_OPIMM, 3'd3, F7_BASE));
            MN_XORI:      e = make(FMT_IA, enc(OPC_OPIMM, 3'd4, F7_BASE));
            MN_ORI:       e = make(FMT_IA, enc(OPC_OPIMM, 3'd6, F7_BASE));
            MN_ANDI:      e = make(FMT_IA, enc(OPC_OPIMM, 3'd7, F7_BASE));
            MN_SLLI:      e = make(FMT_IA, enc(OPC_OPIMM, 3'd1, F7_BASE));
            MN_SRLI:      e = make(FMT_IA, enc(OPC_OPIMM, 3'd5, F7_BASE));
            MN_SRAI:      e = make(FMT_SRAI, enc(OPC_OPIMM, 3'd5, F7_BASE));
            MN_ADD:       e = make(FMT_R, enc(OPC_OP, 3'd0, F7_BASE));
            MN_SUB:       e = make(FMT_R, enc(OPC_OP, 3'd0, F7_ALT));
            MN_SLL:       e = make(FMT_R, enc(OPC_OP, 3'd1, F7_BASE));
            MN_SLT:       e = make(FMT_R, enc(OPC_OP, 3'd2, F7_BASE));
            MN_SLTU:      e = make(FMT_R, enc(OPC_OP, 3'd3, F7_BASE));
            MN_XOR:       e = make(FMT_R, enc(OPC_OP, 3'd4, F7_BASE));
            MN_SRL:       e = make(FMT_R, enc(OPC_OP, 3'd5, F7_BASE));
            MN_SRA:       e = make(FMT_R, enc(OPC_OP, 3'd5, F7_ALT));
            MN_OR:        e = make(FMT_R, enc(OPC_OP, 3'd6, F7_BASE));
            MN_AND:       e = make(FMT_R, enc(OPC_OP, 3'd7, F7_BASE));
            MN_MUL:       e = make(FMT_R, enc(OPC_OP, 3'd0, F7_MULDIV));
            MN_MULH:      e = make(FMT_R, enc(OPC_OP, 3'd1, F7_MULDIV));
            MN_MULHSU:    e = make(FMT_R, enc(OPC_OP, 3'd2, F7_MULDIV));
            MN_MULHU:     e = make(FMT_R, enc(OPC_OP, 3'd3, F7_MULDIV));
            MN_DIV:       e = make(FMT_R, enc(OPC_OP, 3'd4, F7_MULDIV));
            MN_DIVU:      e = make(FMT_R, enc(OPC_OP, 3'd5, F7_MULDIV));
            MN_REM:       e = make(FMT_R, enc(OPC_OP, 3'd6, F7_MULDIV));
            MN_REMU:      e = make(FMT_R, enc(OPC_OP, 3'd7, F7_MULDIV));
            MN_FENCE:     e = make(FMT_FENCE, enc(OPC_FENCE, 3'd0, F7_BASE));
            MN_FENCE_TSO: e = make(FMT_FIXED, WORD_FENCE_TSO);
            MN_ECALL:     e = make(FMT_FIXED, WORD_ECALL);
            MN_EBREAK:    e = make(FMT_FIXED, WORD_EBREAK);
            MN_PAUSE:     e = make(FMT_FIXED, WORD_PAUSE);
            default:      e = '{known: 1'b0, fmt: FMT_FIXED, base: 32'd0};
        endcase
        lookup = e;
    endfunction

endpackage

// ===== hw/rtl/rv32im_instruction_encoder.sv =====
// RV32IM instruction encoder top level: input register, format packing and
// result register. Depends on rvenc_pkg.
//
// Each transaction (start high while busy is low) carries one mnemonic code
// and three operands and yields exactly one encoded word, shown for one cycle
// with o_done high; the receiver cannot stall it, so the word must be
// captured in that cycle. A new transaction is taken in every cycle, so the
// rate is one word per clock; the input register and the result register lie
// around the table lookup and field packing. busy is high only while reset is
// held. Unknown codes give a zero word with o_bad_code set.
module rv32im_instruction_encoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [5:0]         i_opcode,
    input  logic [4:0]         i_operand_a,
    input  logic signed [20:0] i_operand_b,
    input  logic signed [12:0] i_operand_c,
    output logic               o_done,
    output logic [31:0]        o_machine_word,
    output logic               o_bad_code
);

    logic        r_valid;
    logic [5:0]  r_opcode;
    logic [4:0]  r_a;
    logic [20:0] r_b;
    logic [12:0] r_c;

    logic        r_done;
    logic [31:0] r_word;
    logic        r_bad;

    rvenc_pkg::t_code_entry entry;
    logic [31:0]            n_word;
    logic                   accept;

    // Transactions are refused only while reset is held.
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
        end
        if (accept) begin
            r_opcode <= i_opcode;
            r_a      <= i_operand_a;
            r_b      <= i_operand_b;
            r_c      <= i_operand_c;
        end
    end

    // Look up the format and pack the operands into their fields.
    always_comb begin
        entry = rvenc_pkg::lookup(r_opcode);
        case (entry.fmt)
            rvenc_pkg::FMT_U:
                n_word = entry.base | {r_b[19:0], r_a, 7'd0};
            rvenc_pkg::FMT_J:
                n_word = entry.base | {r_b[20], r_b[10:1], r_b[11], r_b[19:12], r_a, 7'd0};
            rvenc_pkg::FMT_I:
                n_word = entry.base | {r_b[11:0], r_c[4:0], 3'd0, r_a, 7'd0};
            rvenc_pkg::FMT_B:
                n_word = entry.base | {r_c[12], r_c[10:5], r_b[4:0], r_a, 3'd0,
                                       r_c[4:1], r_c[11], 7'd0};
            rvenc_pkg::FMT_S:
                n_word = entry.base | {r_b[11:5], r_a, r_c[4:0], 3'd0, r_b[4:0], 7'd0};
            rvenc_pkg::FMT_IA:
                n_word = entry.base | {r_c[11:0], r_b[4:0], 3'd0, r_a, 7'd0};
            rvenc_pkg::FMT_SRAI:
                n_word = entry.base | {rvenc_pkg::SRAI_IMM_HI, r_c[4:0], r_b[4:0], 3'd0,
                                       r_a, 7'd0};
            rvenc_pkg::FMT_R:
                n_word = entry.base | {7'd0, r_c[4:0], r_b[4:0], 3'd0, r_a, 7'd0};
            rvenc_pkg::FMT_FENCE:
                n_word = entry.base | {(r_b[11:0] | {3'd0, r_a, 4'd0}), 20'd0};
            default:
                n_word = entry.base;
        endcase
    end

    // Result register; the word is shown for a single cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_valid;
        end
        if (r_valid) begin
            r_word <= entry.known ? n_word : 32'd0;
            r_bad  <= ~entry.known;
        end
    end

    assign o_done         = r_done;
    assign o_machine_word = r_word;
    assign o_bad_code     = r_bad;

    // Every accepted transaction produces a result after the input and result registers.
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_done)
        else $error("accepted transaction produced no result");

    // No result appears without an earlier accepted transaction.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_rst_n, 2)) |-> $past(accept, 2))
        else $error("result without a transaction");

    // An unknown code gives a zero word.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_bad_code) |-> (o_machine_word == 32'd0))
        else $error("unknown code produced a nonzero word");

    // Every valid RV32 base-length word ends in binary 11.
    a_word_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_bad_code) |-> (o_machine_word[1:0] == 2'b11))
        else $error("encoded word lacks the 32-bit length marker");

endmodule

// ===== verif/rv32im_encoder_checker.sv =====
`timescale 1ns / 1ps
// Checker for the RV32IM instruction encoder: predicts the encoded word of
// every accepted transaction and compares it with the strobed result.
// Depends on rvenc_pkg for the mnemonic and format types and opcode constants.
module rv32im_encoder_checker
    import rvenc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [5:0]         i_opcode,
    input  logic [4:0]         i_operand_a,
    input  logic [20:0]        i_operand_b,
    input  logic [12:0]        i_operand_c,
    input  logic               i_done,
    input  logic [31:0]        i_machine_word,
    input  logic               i_bad_code,
    output int                 o_error_count,
    output int                 o_pending
);

    // One predicted result, with the code that caused it for the error report.
    typedef struct packed {
        logic [5:0]  code;
        logic [31:0] word;
        logic        bad_code;
    } t_encoded_word;

    t_encoded_word pending_words[$];

    // Packs one instruction word from a mnemonic code and its three operands.
    function automatic t_encoded_word encode_instruction(input logic [5:0] code,
                                                         input logic [4:0] a,
                                                         input logic [20:0] b,
                                                         input logic [12:0] c);
        logic [3:0]    fmt;
        logic [6:0]    op;
        logic [2:0]    f3;
        logic [6:0]    f7;
        logic [11:0]   fence_imm;
        t_encoded_word result;
        fmt = FMT_R;
        op = OPC_OP;
        f3 = 3'd0;
        f7 = F7_BASE;
        result.code = code;
        result.bad_code = 1'b0;
        result.word = 32'd0;

        // Class of the mnemonic and its opcode, funct3 and funct7.
        case (code)
            MN_LUI:    begin fmt = FMT_U; op = OPC_LUI; end
            MN_AUIPC:  begin fmt = FMT_U; op = OPC_AUIPC; end
            MN_JAL:    begin fmt = FMT_J; op = OPC_JAL; end
            MN_JALR:   begin fmt = FMT_I; op = OPC_JALR; end
            MN_BEQ:    begin fmt = FMT_B; op = OPC_BRANCH; f3 = 3'd0; end
            MN_BNE:    begin fmt = FMT_B; op = OPC_BRANCH; f3 = 3'd1; end
            MN_BLT:    begin fmt = FMT_B; op = OPC_BRANCH; f3 = 3'd4; end
            MN_BGE:    begin fmt = FMT_B; op = OPC_BRANCH; f3 = 3'd5; end
            MN_BLTU:   begin fmt = FMT_B; op = OPC_BRANCH; f3 = 3'd6; end
            MN_BGEU:   begin fmt = FMT_B; op = OPC_BRANCH; f3 = 3'd7; end
            MN_LB:     begin fmt = FMT_I; op = OPC_LOAD; f3 = 3'd0; end
            MN_LH:     begin fmt = FMT_I; op = OPC_LOAD; f3 = 3'd1; end
            MN_LW:     begin fmt = FMT_I; op = OPC_LOAD; f3 = 3'd2; end
            MN_LBU:    begin fmt = FMT_I; op = OPC_LOAD; f3 = 3'd4; end
            MN_LHU:    begin fmt = FMT_I; op = OPC_LOAD; f3 = 3'd5; end
            MN_SB:     begin fmt = FMT_S; op = OPC_STORE; f3 = 3'd0; end
            MN_SH:     begin fmt = FMT_S; op = OPC_STORE; f3 = 3'd1; end
            MN_SW:     begin fmt = FMT_S; op = OPC_STORE; f3 = 3'd2; end
            MN_ADDI:   begin fmt = FMT_IA; op = OPC_OPIMM; f3 = 3'd0; end
            MN_SLTI:   begin fmt = FMT_IA; op = OPC_OPIMM; f3 = 3'd2; end
            MN_SLTIU:  begin fmt = FMT_IA; op = OPC_OPIMM; f3 = 3'd3; end
            MN_XORI:   begin fmt = FMT_IA; op = OPC_OPIMM; f3 = 3'd4; end
            MN_ORI:    begin fmt = FMT_IA; op = OPC_OPIMM; f3 = 3'd6; end
            MN_ANDI:   begin fmt = FMT_IA; op = OPC_OPIMM; f3 = 3'd7; end
            MN_SLLI:   begin fmt = FMT_IA; op = OPC_OPIMM; f3 = 3'd1; end
            MN_SRLI:   begin fmt = FMT_IA; op = OPC_OPIMM; f3 = 3'd5; end
            MN_SRAI:   begin fmt = FMT_SRAI; op = OPC_OPIMM; f3 = 3'd5; end
            MN_ADD:    begin f3 = 3'd0; end
            MN_SUB:    begin f3 = 3'd0; f7 = F7_ALT; end
            MN_SLL:    begin f3 = 3'd1; end
            MN_SLT:    begin f3 = 3'd2; end
            MN_SLTU:   begin f3 = 3'd3; end
            MN_XOR:    begin f3 = 3'd4; end
            MN_SRL:    begin f3 = 3'd5; end
            MN_SRA:    begin f3 = 3'd5; f7 = F7_ALT; end
            MN_OR:     begin f3 = 3'd6; end
            MN_AND:    begin f3 = 3'd7; end
            MN_MUL:    begin f3 = 3'd0; f7 = F7_MULDIV; end
            MN_MULH:   begin f3 = 3'd1; f7 = F7_MULDIV; end
            MN_MULHSU: begin f3 = 3'd2; f7 = F7_MULDIV; end
            MN_MULHU:  begin f3 = 3'd3; f7 = F7_MULDIV; end
            MN_DIV:    begin f3 = 3'd4; f7 = F7_MULDIV; end
            MN_DIVU:   begin f3 = 3'd5; f7 = F7_MULDIV; end
            MN_REM:    begin f3 = 3'd6; f7 = F7_MULDIV; end
            MN_REMU:   begin f3 = 3'd7; f7 = F7_MULDIV; end
            MN_FENCE:  begin fmt = FMT_FENCE; op = OPC_FENCE; end
            MN_FENCE_TSO, MN_ECALL, MN_EBREAK, MN_PAUSE: begin
                fmt = FMT_FIXED;
            end
            default: begin
                fmt = FMT_FIXED;
                result.bad_code = 1'b1;
            end
        endcase

        // Operand placement; the fixed words ignore every operand.
        fence_imm = b[11:0] | {3'd0, a, 4'd0};
        case (fmt)
            FMT_U:     result.word = {b[19:0], a, op};
            FMT_J:     result.word = {b[20], b[10:1], b[11], b[19:12], a, op};
            FMT_I:     result.word = {b[11:0], c[4:0], f3, a, op};
            FMT_B:     result.word = {c[12], c[10:5], b[4:0], a, f3, c[4:1], c[11], op};
            FMT_S:     result.word = {b[11:5], a, c[4:0], f3, b[4:0], op};
            FMT_IA:    result.word = {c[11:0], b[4:0], f3, a, op};
            FMT_SRAI:  result.word = {SRAI_IMM_HI, c[4:0], b[4:0], f3, a, op};
            FMT_R:     result.word = {f7, c[4:0], b[4:0], f3, a, op};
            FMT_FENCE: result.word = {fence_imm, 5'd0, 3'd0, 5'd0, op};
            default: begin
                case (code)
                    MN_FENCE_TSO: result.word = WORD_FENCE_TSO;
                    MN_ECALL:     result.word = WORD_ECALL;
                    MN_EBREAK:    result.word = WORD_EBREAK;
                    MN_PAUSE:     result.word = WORD_PAUSE;
                    default:      result.word = 32'd0;
                endcase
            end
        endcase
        return result;
    endfunction

    // Results are compared before the transaction of the same edge is queued,
    // since a result always belongs to an earlier transaction. Both counts
    // start at zero as two-state variables.
    always @(posedge i_clk) begin
        t_encoded_word expected;
        if (i_rst_n) begin
            if (i_done) begin
                if (pending_words.size() == 0) begin
                    o_error_count = o_error_count + 1;
                    if (o_error_count <= 10)
                        $display("ERROR: unexpected result word=%08h bad_code=%b",
                                 i_machine_word, i_bad_code);
                end else begin
                    expected = pending_words.pop_front();
                    if (i_machine_word !== expected.word ||
                        i_bad_code !== expected.bad_code) begin
                        o_error_count = o_error_count + 1;
                        if (o_error_count <= 10)
                            $display({"ERROR: code %0d expected word=%08h bad_code=%b,",
                                      " got word=%08h bad_code=%b"},
                                     expected.code, expected.word, expected.bad_code,
                                     i_machine_word, i_bad_code);
                    end
                end
            end
            if (i_start && !i_busy)
                pending_words.push_back(encode_instruction(i_opcode, i_operand_a,
                                                           i_operand_b, i_operand_c));
        end
        o_pending = pending_words.size();
    end

endmodule

// ===== verif/tb_rv32im_instruction_encoder.sv =====
`timescale 1ns / 1ps
// Testbench top for the RV32IM instruction encoder: clock, reset, directed and
// random instruction stimulus with random gaps, and the final verdict.
// Depends on rvenc_pkg, rv32im_instruction_encoder and rv32im_encoder_checker.
module tb_rv32im_instruction_encoder;
    import rvenc_pkg::*;

    // Mnemonic codes above the last instruction are unknown.
    localparam logic [5:0] CODE_UNKNOWN_LO = 6'(MN_PAUSE) + 6'd1;
    localparam logic [5:0] CODE_UNKNOWN_HI = 6'h3F;
    localparam int         RANDOM_ITEMS    = 1950;
    localparam int         DRAIN_CYCLES    = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [5:0]         i_opcode;
    logic [4:0]         i_operand_a;
    logic signed [20:0] i_operand_b;
    logic signed [12:0] i_operand_c;
    logic               o_done;
    logic [31:0]        o_machine_word;
    logic               o_bad_code;
    int                 error_count;
    int                 pending;
    int                 burst_left;

    rv32im_instruction_encoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_operand_c    (i_operand_c),
        .o_done         (o_done),
        .o_machine_word (o_machine_word),
        .o_bad_code     (o_bad_code)
    );

    rv32im_encoder_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_opcode       (i_opcode),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_operand_c    (i_operand_c),
        .i_done         (o_done),
        .i_machine_word (o_machine_word),
        .i_bad_code     (o_bad_code),
        .o_error_count  (error_count),
        .o_pending      (pending)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Idle time before the next transaction: mostly short, some long, with
    // occasional back-to-back bursts.
    function automatic int pick_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left = burst_left - 1;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 3) begin
            burst_left = $urandom_range(80, 20);
            return 0;
        end
        if (roll < 38)
            return 0;
        if (roll < 83)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Random operand value biased toward extremes, short register numbers
    // and sign-extended 12-bit immediates.
    function automatic logic [20:0] pick_operand();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return 21'($urandom);
        if (roll < 70)
            return 21'($urandom_range(31));
        if (roll < 85) begin
            case ($urandom_range(3))
                0:       return 21'h100000;
                1:       return 21'h0FFFFF;
                2:       return 21'h1FFFFF;
                default: return 21'h000000;
            endcase
        end
        return 21'(signed'(12'($urandom)));
    endfunction

    // Presents one transaction and holds it until accepted; during a gap the
    // fields carry noise with start low.
    task automatic send_instruction(input logic [5:0] code, input logic [4:0] a,
                                    input logic [20:0] b, input logic [12:0] c);
        int gap;
        start <= 1'b1;
        i_opcode <= code;
        i_operand_a <= a;
        i_operand_b <= b;
        i_operand_c <= c;
        do
            @(posedge i_clk);
        while (busy);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            i_opcode <= 6'($urandom);
            i_operand_a <= 5'($urandom);
            i_operand_b <= 21'($urandom);
            i_operand_c <= 13'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Run limit, far above the slowest passing run.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Reset, directed cases, random stream, drain and verdict.
    initial begin
        logic [5:0] code;
        burst_left = 0;
        start <= 1'b0;
        i_rst_n <= 1'b0;
        i_opcode <= '0;
        i_operand_a <= '0;
        i_operand_b <= '0;
        i_operand_c <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Operand extremes for each format, shift corner cases, fence bits,
        // fixed words and unknown codes.
        send_instruction(MN_LUI, 5'd31, 21'h0FFFFF, 13'h0000);
        send_instruction(MN_AUIPC, 5'd0, 21'h100000, 13'h0FFF);
        send_instruction(MN_JAL, 5'd31, 21'h1FFFFE, 13'h1FFF);
        send_instruction(MN_JAL, 5'd1, 21'h155555, 13'h0000);
        send_instruction(MN_JALR, 5'd5, 21'h1FFFFF, 13'h1000);
        send_instruction(MN_BEQ, 5'd31, 21'h1FFFFF, 13'h1000);
        send_instruction(MN_BGEU, 5'd0, 21'h000000, 13'h0FFE);
        send_instruction(MN_LW, 5'd1, 21'h000800, 13'h001F);
        send_instruction(MN_SB, 5'd31, 21'h1FFFFF, 13'h1FFF);
        send_instruction(MN_SW, 5'd0, 21'h000FE0, 13'h0000);
        send_instruction(MN_ADDI, 5'd31, 21'h1FFFFF, 13'h1FFF);
        send_instruction(MN_SLTIU, 5'd2, 21'h000000, 13'h0800);
        send_instruction(MN_SLLI, 5'd3, 21'h00001F, 13'h001F);
        send_instruction(MN_SRLI, 5'd4, 21'h100000, 13'h1FFF);
        send_instruction(MN_SRAI, 5'd5, 21'h1FFFFF, 13'h1FFF);
        send_instruction(MN_SRAI, 5'd0, 21'h000000, 13'h0000);
        send_instruction(MN_SUB, 5'd31, 21'h1FFFFF, 13'h1FFF);
        send_instruction(MN_SRA, 5'd7, 21'h000020, 13'h0020);
        send_instruction(MN_REMU, 5'd31, 21'h00001F, 13'h001F);
        send_instruction(MN_FENCE, 5'h1F, 21'h00000F, 13'h1FFF);
        send_instruction(MN_FENCE, 5'h10, 21'h1FFFFF, 13'h0000);
        send_instruction(MN_FENCE_TSO, 5'd31, 21'h1FFFFF, 13'h1FFF);
        send_instruction(MN_ECALL, 5'd31, 21'h1FFFFF, 13'h1FFF);
        send_instruction(MN_EBREAK, 5'd9, 21'h155555, 13'h0AAA);
        send_instruction(MN_PAUSE, 5'd31, 21'h1FFFFF, 13'h1FFF);
        send_instruction(CODE_UNKNOWN_LO, 5'd31, 21'h1FFFFF, 13'h1FFF);
        send_instruction(CODE_UNKNOWN_HI, 5'd0, 21'h000000, 13'h0000);

        // Random instructions, mostly known mnemonics.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(99) < 90)
                code = 6'($urandom_range(MN_PAUSE));
            else
                code = 6'($urandom_range(CODE_UNKNOWN_HI, CODE_UNKNOWN_LO));
            send_instruction(code, 5'($urandom), pick_operand(), 13'(pick_operand()));
        end
        start <= 1'b0;

        // Wait for every outstanding result, then let the pipeline settle.
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending != 0)
            $display("ERROR: %0d results never arrived", pending);
        if (error_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
